// ===== rtl/core/iot_pkg.sv =====
// Package for the intermittent output timer.
// Holds widths, the count cap, register indexes and the structs shared by the core modules.
// No dependencies.
package iot_pkg;

    localparam int unsigned CountW   = 16;
    localparam int unsigned CycW     = 16;
    localparam int unsigned TotalW   = CountW + 1;
    localparam int unsigned CfgIdxW  = 8;
    localparam int unsigned CfgDataW = 16;
    localparam int unsigned InDataW  = 8;
    localparam int unsigned OutDataW = 40;

    localparam logic [CountW-1:0] COUNT_CAP = 16'd60000;

    typedef enum logic [CfgIdxW-1:0] {
        REG_ON_TICKS      = 8'd0,
        REG_OFF_TICKS     = 8'd1,
        REG_CYCLE_LIMIT   = 8'd2,
        REG_REPEAT_ENABLE = 8'd3
    } cfg_index_t;

    typedef struct packed {
        logic [CountW-1:0] on_ticks;
        logic [CountW-1:0] off_ticks;
        logic [CycW-1:0]   cycle_limit;
        logic              repeat_enable;
    } cfg_t;

    typedef struct packed {
        logic [CountW-1:0] phase_count;
        logic [CycW-1:0]   repeat_count;
        logic              drive_level;
    } timer_state_t;

endpackage

// ===== rtl/core/iot_cfg_regs.sv =====
// Configuration register file for the intermittent output timer.
// Decodes indexed writes into the four timer settings; depends on iot_pkg.
module iot_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [iot_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [iot_pkg::CfgDataW-1:0]  cfg_data,
    output iot_pkg::cfg_t                 cfg
);

    iot_pkg::cfg_t cfg_reg;
    iot_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                iot_pkg::REG_ON_TICKS:      cfg_next.on_ticks      = cfg_data;
                iot_pkg::REG_OFF_TICKS:     cfg_next.off_ticks     = cfg_data;
                iot_pkg::REG_CYCLE_LIMIT:   cfg_next.cycle_limit   = cfg_data;
                iot_pkg::REG_REPEAT_ENABLE: cfg_next.repeat_enable = cfg_data[0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/iot_step.sv =====
// Per-tick next-state logic of the intermittent output timer.
// Purely combinational; depends on iot_pkg for the count cap and the shared structs.
module iot_step (
    input  iot_pkg::cfg_t         cfg,
    input  iot_pkg::timer_state_t cur,
    input  logic                  condition,
    output iot_pkg::timer_state_t nxt
);

    logic [iot_pkg::TotalW-1:0] total;
    logic [iot_pkg::CountW-1:0] advanced;
    logic                       limit_ok;
    logic                       run_cond;
    logic                       run_phase;
    logic                       run_repeat;
    logic [iot_pkg::CountW-1:0] phase_mid;
    logic [iot_pkg::CycW-1:0]   repeat_mid;
    logic                       drive_on;

    assign total    = {1'b0, cfg.on_ticks} + {1'b0, cfg.off_ticks};
    assign advanced = (cur.phase_count > iot_pkg::COUNT_CAP) ? iot_pkg::COUNT_CAP
                                                             : cur.phase_count + 16'd1;

    assign limit_ok   = (cur.repeat_count < cfg.cycle_limit) || (cfg.cycle_limit == '0);
    assign run_cond   = condition && limit_ok;
    assign run_phase  = (cur.phase_count != '0) && ({1'b0, cur.phase_count} < total);
    assign run_repeat = (cur.repeat_count != '0) && (cur.repeat_count < cfg.cycle_limit);

    always_comb
    begin
        phase_mid  = cur.phase_count;
        repeat_mid = cur.repeat_count;
        priority if (run_cond || run_phase || run_repeat)
        begin
            phase_mid = advanced;
        end
        else
        begin
            phase_mid = '0;
            if (!condition)
            begin
                repeat_mid = '0;
            end
        end
    end

    assign drive_on = (phase_mid != '0) && (phase_mid < cfg.on_ticks);

    always_comb
    begin
        nxt = cur;
        if (cfg.on_ticks != '0)
        begin
            nxt.phase_count  = phase_mid;
            nxt.repeat_count = repeat_mid;
            nxt.drive_level  = drive_on;
            if (!drive_on && cfg.repeat_enable && ({1'b0, phase_mid} >= total))
            begin
                nxt.phase_count  = '0;
                nxt.repeat_count = repeat_mid + 16'd1;
            end
        end
    end

endmodule

// ===== rtl/core/intermittent_output_timer_unit.sv =====
// Top level of the intermittent output timer: input register, timer state and result register.
// Instantiates iot_cfg_regs and iot_step; depends on iot_pkg.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata[0] condition
//   m_axis    out        tdata[0] output_on, [16:1] elapsed_ticks, [32:17] cycles_done
//   cfg       in         cfg_index selects the register, cfg_data carries the value
//
// A tick is held in the input register and its result is registered in the result register.
// One tick is taken per cycle while the result register drains; the timer state path
// through iot_step is the only logic between the two registers.
// Reset clears the settings, the timer state and both valid flags.
// A stalled result holds its register; once the input register is also full, it holds
// that register too and s_axis_tready drops.
module intermittent_output_timer_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [iot_pkg::InDataW-1:0]    s_axis_tdata,   // [0] condition, rest zero
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [iot_pkg::OutDataW-1:0]   m_axis_tdata,   // [0] output_on, [16:1] elapsed_ticks,
                                                           // [32:17] cycles_done, rest zero
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [iot_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [iot_pkg::CfgDataW-1:0]   cfg_data
);

    iot_pkg::cfg_t         cfg;
    iot_pkg::timer_state_t state_reg;
    iot_pkg::timer_state_t state_next;

    logic in_valid_reg;
    logic cond_reg;
    logic out_valid_reg;
    logic step_go;

    logic [iot_pkg::OutDataW-1:0] out_data_reg;

    iot_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    iot_step u_step (
        .cfg       (cfg),
        .cur       (state_reg),
        .condition (cond_reg),
        .nxt       (state_next)
    );

    assign step_go       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step_go;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (step_go)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            cond_reg <= s_axis_tdata[0];
        end
        if (step_go)
        begin
            out_data_reg <= {7'd0, state_next.repeat_count, state_next.phase_count,
                             state_next.drive_level};
        end
    end

`ifndef ASSERT_OFF
    a_phase_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase_count <= iot_pkg::COUNT_CAP + 16'd1)
        else $error("phase count above cap plus one");

    a_disabled_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (step_go && cfg.on_ticks == '0) |=> $stable(state_reg))
        else $error("disabled channel changed its state");

    a_drive_in_on_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (step_go && cfg.on_ticks != '0)
            |-> (state_next.drive_level == (state_next.phase_count != '0
                                            && state_next.phase_count < cfg.on_ticks)))
        else $error("output on outside the on phase");

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a blocked result");

    a_result_follows_step: assert property (@(posedge clk) disable iff (!rst_n)
        step_go |=> out_valid_reg)
        else $error("processed tick produced no result");
`endif

endmodule
